>>> rtl/core/sfr_pkg.sv
// Shared types and constants for the streaming find-and-replace block.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PATTERN_BYTES     = 2'd0,
    REG_PATTERN_LENGTH    = 2'd1,
    REG_REPLACEMENT_BYTES = 2'd2,
    REG_REPLACEMENT_LEN   = 2'd3
  } cfg_reg_e;

  // one result item as it moves toward the output
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic              last;
  } result_t;

  // per-cell controls of the pending window
  typedef struct packed {
    logic en;      // item transfer this cycle
    logic ins;     // incoming byte lands in this cell
    logic shift;   // window drops its oldest byte
    logic active;  // cell index below pattern length
  } win_ctl_t;

  // per-cell controls of the result queue
  typedef struct packed {
    logic load;
    logic shift;
  } slot_ctl_t;

endpackage

>>> rtl/core/sfr_win_cell.sv
// One byte of the pending window with its pattern comparator.
// Depends on sfr_pkg; instantiated in a row by stream_find_replace_top.
`timescale 1ns / 1ps

module sfr_win_cell import sfr_pkg::*; (
  input  logic              clk,
  input  win_ctl_t          ctl,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic [BYTE_W-1:0] nb_byte,
  input  logic [BYTE_W-1:0] pat_byte,
  input  logic              eq_in,
  output logic [BYTE_W-1:0] cur_byte,
  output logic              eq_out
);

  logic [BYTE_W-1:0] stored;

  // window contents as seen after the incoming byte is placed
  assign cur_byte = ctl.ins ? text_byte : stored;
  assign eq_out   = eq_in & (!ctl.active | (cur_byte == pat_byte));

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      stored <= ctl.shift ? nb_byte : cur_byte;
    end
  end

endmodule

>>> rtl/core/sfr_slot_cell.sv
// One slot of the result queue; slots shift toward the output register.
// Depends on sfr_pkg; instantiated in a row by stream_find_replace_top.
`timescale 1ns / 1ps

module sfr_slot_cell import sfr_pkg::*; (
  input  logic      clk,
  input  slot_ctl_t ctl,
  input  result_t   load_val,
  input  result_t   nb_val,
  output result_t   held
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      held <= load_val;
    end else if (ctl.shift) begin
      held <= nb_val;
    end
  end

endmodule

>>> rtl/core/stream_find_replace_top.sv
// Streaming find-and-replace: window cells, result queue cells, output register.
// Depends on sfr_pkg, sfr_win_cell and sfr_slot_cell.
//
//   port group  dir  flow control       payload
//   in          in   in_valid/in_stall  text_byte, byte_present, end_of_text
//   res         out  res_valid/res_stall out_byte, out_valid, out_last
//   cfg         in   cfg_write          cfg_addr, cfg_data
//
// An item is taken in the cycle it arrives when it yields at most one result and
// the output drains: one item per cycle. An item with more results (match expansion
// or end-of-text flush) fills the result queue and holds in_stall high while the
// queue drains through the output register.
// in_stall comes from registered queue state only; res_stall backs up the queue.
// Reset clears the window count, the queue and the output valid; registers
// return to their defaults (pattern length one, empty replacement).
`timescale 1ns / 1ps

module stream_find_replace_top import sfr_pkg::*; #(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     text_byte,
  input  logic                  byte_present,
  input  logic                  end_of_text,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  out_valid,
  output logic                  out_last,
  input  logic                  cfg_write,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RES_MAX   = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
  localparam int CNT_W     = $clog2(PATTERN_MAX + 1);
  localparam int RCNT_W    = $clog2(RES_MAX + 1);
  localparam int REP_STORE = (REPLACE_MAX > 0) ? REPLACE_MAX : 1;

  // configuration
  logic [BYTE_W*PATTERN_MAX-1:0] pat_bytes;
  logic [LEN_W-1:0]              pat_len_reg;
  logic [BYTE_W*REP_STORE-1:0]   rep_bytes;
  logic [LEN_W-1:0]              rep_len_reg;

  logic [CNT_W-1:0]  plen;
  logic [RCNT_W-1:0] rlen;

  // window state
  logic [CNT_W-1:0]  win_cnt;
  logic [CNT_W-1:0]  win_cnt_next;
  logic [CNT_W-1:0]  cv;
  logic [BYTE_W-1:0] cur [PATTERN_MAX];
  logic              eq  [PATTERN_MAX+1];

  // result queue and output register
  logic [RCNT_W-1:0] burst_cnt;
  logic [RCNT_W-1:0] burst_cnt_next;
  result_t           res  [RES_MAX+1];
  result_t           slot [RES_MAX];
  slot_ctl_t         sctl;

  logic              accept;
  logic              full;
  logic              hit;
  logic              out_free;
  logic [RCNT_W-1:0] n_res;
  logic [RCNT_W-1:0] n_eff;
  logic              out_load;
  result_t           out_next;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_bytes   <= '0;
      pat_len_reg <= LEN_W'(1);
      rep_bytes   <= '0;
      rep_len_reg <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_addr))
        REG_PATTERN_BYTES:     pat_bytes   <= cfg_data[BYTE_W*PATTERN_MAX-1:0];
        REG_PATTERN_LENGTH:    pat_len_reg <= cfg_data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES: rep_bytes   <= cfg_data[BYTE_W*REP_STORE-1:0];
        REG_REPLACEMENT_LEN:   rep_len_reg <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pat_len_reg == '0) begin
      plen = CNT_W'(1);
    end else if (pat_len_reg > LEN_W'(PATTERN_MAX)) begin
      plen = CNT_W'(PATTERN_MAX);
    end else begin
      plen = pat_len_reg[CNT_W-1:0];
    end
    if (rep_len_reg > LEN_W'(REPLACE_MAX)) begin
      rlen = RCNT_W'(REPLACE_MAX);
    end else begin
      rlen = RCNT_W'(rep_len_reg);
    end
  end

  // ---------------------------------------------------------------- window
  assign accept = in_valid && !in_stall;
  assign cv     = byte_present ? win_cnt + CNT_W'(1) : win_cnt;
  assign full   = byte_present && (cv == plen);
  assign hit    = full && eq[PATTERN_MAX];
  assign eq[0]  = 1'b1;

  genvar i;
  generate
    for (i = 0; i < PATTERN_MAX; i++) begin : g_win
      win_ctl_t          wctl;
      logic [BYTE_W-1:0] nb;

      assign wctl.en     = accept;
      assign wctl.ins    = byte_present && (win_cnt == CNT_W'(i));
      assign wctl.shift  = full && !hit;
      assign wctl.active = plen > CNT_W'(i);

      if (i == PATTERN_MAX - 1) begin : g_end
        assign nb = cur[i];
      end else begin : g_mid
        assign nb = cur[i+1];
      end

      sfr_win_cell u_cell (
        .clk       (clk),
        .ctl       (wctl),
        .text_byte (text_byte),
        .nb_byte   (nb),
        .pat_byte  (pat_bytes[BYTE_W*i +: BYTE_W]),
        .eq_in     (eq[i]),
        .cur_byte  (cur[i]),
        .eq_out    (eq[i+1])
      );
    end
  endgenerate

  always_comb begin
    if (cfg_write && (cfg_reg_e'(cfg_addr) == REG_PATTERN_LENGTH)) begin
      win_cnt_next = '0;
    end else if (accept) begin
      if (end_of_text || hit) begin
        win_cnt_next = '0;
      end else if (full) begin
        win_cnt_next = cv - CNT_W'(1);
      end else begin
        win_cnt_next = cv;
      end
    end else begin
      win_cnt_next = win_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cnt <= '0;
    end else begin
      win_cnt <= win_cnt_next;
    end
  end

  // ---------------------------------------------------------------- results
  // a match emits the replacement; otherwise the window itself is the source
  always_comb begin
    if (hit) begin
      n_res = rlen;
    end else if (end_of_text) begin
      n_res = RCNT_W'(cv);
    end else if (full) begin
      n_res = RCNT_W'(1);
    end else begin
      n_res = '0;
    end
    // end with nothing left still gives one empty result
    n_eff = (end_of_text && (n_res == '0)) ? RCNT_W'(1) : n_res;
  end

  genvar k;
  generate
    for (k = 0; k < RES_MAX; k++) begin : g_res
      logic [BYTE_W-1:0] rep_b;
      logic [BYTE_W-1:0] win_b;

      if (k < REPLACE_MAX) begin : g_rep
        assign rep_b = rep_bytes[BYTE_W*k +: BYTE_W];
      end else begin : g_norep
        assign rep_b = '0;
      end

      if (k < PATTERN_MAX) begin : g_w
        assign win_b = cur[k];
      end else begin : g_now
        assign win_b = '0;
      end

      assign res[k].data  = (n_res == '0) ? '0 : (hit ? rep_b : win_b);
      assign res[k].valid = n_res != '0;
      assign res[k].last  = end_of_text && (RCNT_W'(k) == n_eff - RCNT_W'(1));
    end
  endgenerate

  assign res[RES_MAX] = '0;

  // ---------------------------------------------------------------- queue
  assign in_stall   = burst_cnt != '0;
  assign out_free   = !res_valid || !res_stall;
  assign sctl.shift = out_free && (burst_cnt != '0);
  assign sctl.load  = accept;

  genvar j;
  generate
    for (j = 0; j < RES_MAX; j++) begin : g_slot
      result_t ld;
      result_t nb;

      // first result goes straight to the output register when it is free
      assign ld = out_free ? res[j+1] : res[j];

      if (j == RES_MAX - 1) begin : g_end
        assign nb = '0;
      end else begin : g_mid
        assign nb = slot[j+1];
      end

      sfr_slot_cell u_slot (
        .clk      (clk),
        .ctl      (sctl),
        .load_val (ld),
        .nb_val   (nb),
        .held     (slot[j])
      );
    end
  endgenerate

  always_comb begin
    burst_cnt_next = burst_cnt;
    out_load       = 1'b0;
    out_next       = res[0];
    if (sctl.shift) begin
      burst_cnt_next = burst_cnt - RCNT_W'(1);
      out_load       = 1'b1;
      out_next       = slot[0];
    end else if (accept && (n_eff != '0)) begin
      if (out_free) begin
        burst_cnt_next = n_eff - RCNT_W'(1);
        out_load       = 1'b1;
      end else begin
        burst_cnt_next = n_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_cnt <= '0;
      res_valid <= 1'b0;
    end else begin
      burst_cnt <= burst_cnt_next;
      if (out_free) begin
        res_valid <= out_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && out_load) begin
      out_byte  <= out_next.data;
      out_valid <= out_next.valid;
      out_last  <= out_next.last;
    end
  end

  // ---------------------------------------------------------------- checks
  a_queue_behind_out: assert property (@(posedge clk) disable iff (rst)
    (burst_cnt != '0) |-> res_valid)
    else $error("result queue holds data while output register is empty");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    burst_cnt <= RCNT_W'(RES_MAX))
    else $error("result queue count out of range");

  a_window_short: assert property (@(posedge clk) disable iff (rst)
    win_cnt < plen)
    else $error("pending window reached pattern length");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |=> (win_cnt == '0))
    else $error("window not empty after end of text");

endmodule

>>> tb/sfr_checker.sv
// Checker for stream_find_replace_top: tracks register writes and text transfers,
// predicts the rewritten byte stream and compares every result transfer.
// Depends on sfr_pkg for the register codes and the result item layout.
`timescale 1ns / 1ps

module sfr_checker import sfr_pkg::*; #(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [BYTE_W-1:0]     text_byte,
  input  logic                  byte_present,
  input  logic                  end_of_text,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  logic [BYTE_W-1:0]     out_byte,
  input  logic                  out_valid,
  input  logic                  out_last,
  input  logic                  cfg_write,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_results,
  output int                    results_checked
);

  localparam int WIN_DEPTH = 8;

  logic [CFG_DATA_W-1:0] pat_bytes;
  logic [CFG_DATA_W-1:0] rep_bytes;
  logic [LEN_W-1:0]      pat_len_q;
  logic [LEN_W-1:0]      rep_len_q;
  logic [BYTE_W-1:0]     win [WIN_DEPTH];
  int                    win_cnt;
  result_t               rewritten_q [$];
  result_t               head;

  function automatic result_t mk_result(input logic [BYTE_W-1:0] d, input logic v,
                                        input logic l);
    result_t r;
    r.data  = d;
    r.valid = v;
    r.last  = l;
    return r;
  endfunction

  task automatic report(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    fail_count++;
  endtask

  // Expected results of one text transfer, appended to rewritten_q.
  task automatic rewrite_item(input logic [BYTE_W-1:0] b, input logic present,
                              input logic eot);
    result_t res [8];
    int      k;
    int      i;
    int      plen;
    int      rlen;
    logic    hit;
    k = 0;
    if (pat_len_q == 0) plen = 1;
    else if (pat_len_q > PATTERN_MAX) plen = PATTERN_MAX;
    else plen = int'(pat_len_q);
    rlen = (rep_len_q > REPLACE_MAX) ? REPLACE_MAX : int'(rep_len_q);

    if (present && win_cnt < WIN_DEPTH) begin
      win[win_cnt] = b;
      win_cnt++;
    end

    if (present && win_cnt >= plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++)
        if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (i = 0; i < rlen; i++) begin
          res[k] = mk_result(rep_bytes[8*i +: 8], 1'b1, 1'b0);
          k++;
        end
        win_cnt = 0;
      end else begin
        res[k] = mk_result(win[0], 1'b1, 1'b0);
        k++;
        for (i = 1; i < win_cnt; i++) win[i-1] = win[i];
        win_cnt--;
      end
    end

    if (eot) begin
      for (i = 0; i < win_cnt && k < 8; i++) begin
        res[k] = mk_result(win[i], 1'b1, 1'b0);
        k++;
      end
      win_cnt = 0;
      // nothing left to emit: a lone empty marker closes the text
      if (k == 0) begin
        res[0] = mk_result('0, 1'b0, 1'b1);
        k = 1;
      end else begin
        res[k-1].last = 1'b1;
      end
    end

    for (i = 0; i < k; i++) rewritten_q.push_back(res[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pat_bytes       = '0;
      rep_bytes       = '0;
      pat_len_q       = 4'd1;
      rep_len_q       = '0;
      win_cnt         = 0;
      fail_count      = 0;
      results_checked = 0;
      rewritten_q.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (rewritten_q.size() == 0) begin
          report($sformatf("result transfer with none expected: byte %02h valid %0b last %0b",
                           out_byte, out_valid, out_last));
        end else begin
          head = rewritten_q.pop_front();
          if (out_byte !== head.data)
            report($sformatf("out_byte %02h, expected %02h", out_byte, head.data));
          if (out_valid !== head.valid)
            report($sformatf("out_valid %0b, expected %0b (byte %02h)", out_valid,
                             head.valid, head.data));
          if (out_last !== head.last)
            report($sformatf("out_last %0b, expected %0b (byte %02h)", out_last,
                             head.last, head.data));
          results_checked++;
        end
      end

      if (cfg_write) begin
        case (cfg_reg_e'(cfg_addr))
          REG_PATTERN_BYTES:     pat_bytes = cfg_data;
          REG_PATTERN_LENGTH: begin
            pat_len_q = cfg_data[LEN_W-1:0];
            win_cnt   = 0;  // pending bytes dropped on every length write
          end
          REG_REPLACEMENT_BYTES: rep_bytes = cfg_data;
          REG_REPLACEMENT_LEN:   rep_len_q = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) rewrite_item(text_byte, byte_present, end_of_text);
    end
    pending_results = rewritten_q.size();
  end

endmodule

>>> tb/tb_top.sv
// Testbench top for stream_find_replace_top: clock, reset, register writes, text
// stimulus under several idle/stall mixes, and the verdict. Depends on sfr_pkg,
// the RTL under rtl/core and tb/sfr_checker.sv.
`timescale 1ns / 1ps

module tb_top import sfr_pkg::*;;

  localparam int IDLE_GAP     = 8;   // cycles allowed for in-flight work to settle
  localparam int PHASE_ITEMS  = 22;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     text_byte   = '0;
  logic                  byte_present = 1'b0;
  logic                  end_of_text = 1'b0;
  logic                  res_valid;
  logic                  res_stall   = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_valid;
  logic                  out_last;
  logic                  cfg_write   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  int fail_count;
  int pending_results;
  int results_checked;

  int send_idle_pct = 0;
  int rx_stall_pct  = 0;
  int text_items    = 0;

  // generator's view of the pattern, used only to build matching text
  logic [CFG_DATA_W-1:0] gen_pat      = '0;
  logic [LEN_W-1:0]      gen_plen_reg = 4'd1;
  int                    gen_plen     = 1;

  always #5 clk = ~clk;

  stream_find_replace_top #(.PATTERN_MAX(8), .REPLACE_MAX(8)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .text_byte(text_byte), .byte_present(byte_present), .end_of_text(end_of_text),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_byte(out_byte), .out_valid(out_valid), .out_last(out_last),
    .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  sfr_checker #(.PATTERN_MAX(8), .REPLACE_MAX(8)) u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .text_byte(text_byte), .byte_present(byte_present), .end_of_text(end_of_text),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_byte(out_byte), .out_valid(out_valid), .out_last(out_last),
    .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_results(pending_results),
    .results_checked(results_checked)
  );

  always @(negedge clk) begin
    res_stall <= (rx_stall_pct > 0) && ($urandom_range(99) < rx_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic present,
                           input logic eot);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    text_byte    <= b;
    byte_present <= present;
    end_of_text  <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (present || eot) text_items++;
  endtask

  // Stop sending and let every expected result come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic cfg_wr(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    if (idx == REG_PATTERN_BYTES) gen_pat = val;
    if (idx == REG_PATTERN_LENGTH) begin
      gen_plen_reg = val[LEN_W-1:0];
      gen_plen = (val[LEN_W-1:0] == 0) ? 1 :
                 (val[LEN_W-1:0] > 8) ? 8 : int'(val[LEN_W-1:0]);
    end
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] pat, input logic [LEN_W-1:0] plen,
                            input logic [CFG_DATA_W-1:0] rep, input logic [LEN_W-1:0] rlen);
    cfg_wr(REG_PATTERN_BYTES, pat);
    cfg_wr(REG_PATTERN_LENGTH, CFG_DATA_W'(plen));
    cfg_wr(REG_REPLACEMENT_BYTES, rep);
    cfg_wr(REG_REPLACEMENT_LEN, CFG_DATA_W'(rlen));
  endtask

  // One text: whole pattern copies, broken prefixes, stray bytes and ignored items.
  task automatic send_random_text();
    int len;
    int sent;
    int r;
    int n;
    int i;
    int idx;
    len  = $urandom_range(12);
    sent = 0;
    while (sent < len) begin
      r = $urandom_range(99);
      if (r < 35) begin
        for (i = 0; i < gen_plen; i++) send_item(gen_pat[8*i +: 8], 1'b1, 1'b0);
        sent += gen_plen;
      end else if (r < 50 && gen_plen > 1) begin
        n = $urandom_range(gen_plen - 1, 1);
        for (i = 0; i < n; i++) send_item(gen_pat[8*i +: 8], 1'b1, 1'b0);
        sent += n;
      end else if (r < 55) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      end else begin
        idx = $urandom_range(gen_plen - 1);
        if ($urandom_range(1)) send_item(gen_pat[8*idx +: 8], 1'b1, 1'b0);
        else send_item(8'($urandom_range(255)), 1'b1, 1'b0);
        sent++;
      end
    end
    // now and then rewrite the length mid-text, which drops the pending bytes
    if ($urandom_range(99) < 15) begin
      wait_idle();
      cfg_wr(REG_PATTERN_LENGTH, CFG_DATA_W'(gen_plen_reg));
    end
    send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input logic [LEN_W-1:0] plen,
                           input logic [LEN_W-1:0] rlen, input bit two_letters);
    logic [CFG_DATA_W-1:0] pat;
    int i;
    int start;
    // a two-letter pattern makes self-overlapping matches common
    for (i = 0; i < 8; i++)
      pat[8*i +: 8] = two_letters ? 8'(8'h61 + $urandom_range(1)) : 8'($urandom_range(255));
    set_config(pat, plen, {$urandom, $urandom}, rlen);
    send_idle_pct = s_pct;
    rx_stall_pct  = r_pct;
    start = text_items;
    while (text_items - start < PHASE_ITEMS) send_random_text();
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // defaults: one-byte pattern 00, empty replacement, so zero bytes are deleted
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);   // match then end with nothing left
    send_item(8'h5A, 1'b0, 1'b0);   // ignored item
    send_item(8'hA5, 1'b0, 1'b1);   // bare end marker, empty window
    wait_idle();

    // "abc" -> eight bytes; partial text cut by a length rewrite
    set_config(64'h0000_0000_0063_6261, 4'd3, 64'h0123_4567_89AB_CDEF, 4'd8);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    wait_idle();
    cfg_wr(REG_PATTERN_LENGTH, 64'd3);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h78, 1'b1, 1'b1);   // miss on a full window, then flush
    wait_idle();

    // out-of-range lengths saturate: eight FF bytes -> eight zero bytes
    set_config({CFG_DATA_W{1'b1}}, 4'd15, '0, 4'd12);
    repeat (7) send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    wait_idle();

    run_phase(0,  0,  4'd0, 4'd0, 1'b1);
    run_phase(63, 0,  4'd8, 4'd8, 1'b0);
    run_phase(0,  63, 4'($urandom_range(7, 2)), 4'd15, 1'b1);
    run_phase(14, 14, 4'd9, 4'($urandom_range(7, 1)), 1'b0);

    send_idle_pct = 0;
    rx_stall_pct  = 0;
    repeat (IDLE_GAP) @(negedge clk);

    $display("Sent %0d text items over seven register settings and four idle/stall mixes.",
             text_items);
    $display("Checked %0d result transfers; %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d results still expected", pending_results);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> stream_find_replace_top.f
rtl/core/sfr_pkg.sv
rtl/core/sfr_win_cell.sv
rtl/core/sfr_slot_cell.sv
rtl/core/stream_find_replace_top.sv
tb/sfr_checker.sv
tb/tb_top.sv
